@@ hw/rtl/gha_pkg.sv @@
// ----------------------------------------------------------------------------
// gha_pkg: shared definitions for the generational handle allocator
// Table geometry, field widths, opcode and status codes, stream packing.
// ----------------------------------------------------------------------------
package gha_pkg;

    // table geometry and field widths
    localparam int SLOTS  = 256;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int REF_W  = 32;
    localparam int CODE_W = 32;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    // stream payload widths, padded to whole bytes
    localparam int IN_BITS  = OP_W + REF_W + IDX_W + CODE_W;
    localparam int OUT_BITS = ST_W + IDX_W + CODE_W + REF_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // field offsets in the input item, lowest first
    localparam int IN_OP_LO   = 0;
    localparam int IN_REF_LO  = IN_OP_LO + OP_W;
    localparam int IN_IDX_LO  = IN_REF_LO + REF_W;
    localparam int IN_CODE_LO = IN_IDX_LO + IDX_W;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_RSVD   = 2'd3
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD      = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

endpackage

@@ hw/rtl/generational_handle_allocator.sv @@
// ----------------------------------------------------------------------------
// generational_handle_allocator: slot map with LIFO free list
// Allocates, frees and looks up generation-stamped handles, one item a cycle while the receiver keeps up.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on the s_axis channel (opcode, object reference, index,
//   code) and each gives exactly one result item on m_axis (status, index,
//   code, found reference).
//   An accepted item sits in the input register while the slot and free-stack
//   memories are read; it then executes against the table state once the result
//   register is free or being emptied, and lands in the result register. A new
//   item is taken every cycle while the receiver keeps up (one memory read
//   and one write per store per item; writes from the item ahead are
//   forwarded to the item behind it).
//   Reset clears the in-use flags, the free-stack count, the fresh-index
//   counter (to 1) and the generation counter.
//   When the receiver stalls, the result register holds and the input
//   register fills; s_axis_tready then drops until the result is taken.
// ----------------------------------------------------------------------------
module generational_handle_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // opcode, object_ref, handle_index, handle_code, zero pad
    input  logic [gha_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // status, result_index, result_code, found_ref, zero pad
    output logic [gha_pkg::OUT_W-1:0]  m_axis_tdata
);
    import gha_pkg::*;

    // handshake
    logic w_in_acc;
    logic w_commit;

    // input register
    logic              r_in_valid;
    t_opcode           r_op;
    logic [REF_W-1:0]  r_obj;
    logic [IDX_W-1:0]  r_idx;
    logic [CODE_W-1:0] r_code_in;

    // table state
    logic [SLOTS-1:0]  r_in_use, n_in_use;
    logic [CNT_W-1:0]  r_free_count, n_free_count;
    logic [CNT_W-1:0]  r_next_fresh, n_next_fresh;
    logic [CODE_W-1:0] r_gen, n_gen;

    // memories and their registered read data
    logic [REF_W-1:0]  slot_ref_mem [SLOTS];
    logic [CODE_W-1:0] slot_gen_mem [SLOTS];
    logic [IDX_W-1:0]  stack_mem    [SLOTS];
    logic [REF_W-1:0]  r_ref_rd;
    logic [CODE_W-1:0] r_gen_rd;
    logic [IDX_W-1:0]  r_stk_rd;
    logic [IDX_W-1:0]  w_stk_raddr;

    // last-write forwarding
    logic              r_slot_wr_valid;
    logic [IDX_W-1:0]  r_slot_wr_addr;
    logic [REF_W-1:0]  r_slot_wr_ref;
    logic [CODE_W-1:0] r_slot_wr_gen;
    logic              r_stk_wr_valid;
    logic [IDX_W-1:0]  r_stk_wr_addr;
    logic [IDX_W-1:0]  r_stk_wr_data;
    logic [REF_W-1:0]  w_ref_fwd;
    logic [CODE_W-1:0] w_gen_fwd;
    logic [IDX_W-1:0]  w_stk_fwd;
    logic [IDX_W-1:0]  w_stk_top;

    // write ports
    logic              w_slot_we;
    logic [IDX_W-1:0]  w_slot_waddr;
    logic              w_stk_we;
    logic [IDX_W-1:0]  w_stk_waddr;

    // result
    logic              r_out_valid;
    t_status           r_status, n_status;
    logic [IDX_W-1:0]  r_res_idx, n_res_idx;
    logic [CODE_W-1:0] r_res_code, n_res_code;
    logic [REF_W-1:0]  r_found_ref, n_found_ref;

    // handshake: execute when the result register is free or being emptied
    assign w_commit      = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_commit;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // take the input item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op      <= t_opcode'(s_axis_tdata[IN_OP_LO +: OP_W]);
            r_obj     <= s_axis_tdata[IN_REF_LO +: REF_W];
            r_idx     <= s_axis_tdata[IN_IDX_LO +: IDX_W];
            r_code_in <= s_axis_tdata[IN_CODE_LO +: CODE_W];
        end
    end

    // forward the last write where it hits the entry just read
    assign w_stk_top = IDX_W'(r_free_count - CNT_W'(1));
    assign w_ref_fwd = (r_slot_wr_valid && r_slot_wr_addr == r_idx) ? r_slot_wr_ref : r_ref_rd;
    assign w_gen_fwd = (r_slot_wr_valid && r_slot_wr_addr == r_idx) ? r_slot_wr_gen : r_gen_rd;
    assign w_stk_fwd = (r_stk_wr_valid && r_stk_wr_addr == w_stk_top) ? r_stk_wr_data
                                                                       : r_stk_rd;

    // execute the item against the table
    always_comb begin
        n_in_use     = r_in_use;
        n_free_count = r_free_count;
        n_next_fresh = r_next_fresh;
        n_gen        = r_gen;
        n_status     = ST_BAD;
        n_res_idx    = '0;
        n_res_code   = '0;
        n_found_ref  = '0;
        w_slot_we    = 1'b0;
        w_slot_waddr = r_idx;
        w_stk_we     = 1'b0;
        w_stk_waddr  = r_free_count[IDX_W-1:0];
        if (w_commit) begin
            case (r_op)
                OP_ALLOC: begin
                    if (r_free_count != '0) begin
                        // reuse the most recently freed index
                        w_slot_we    = 1'b1;
                        w_slot_waddr = w_stk_fwd;
                        n_free_count = r_free_count - CNT_W'(1);
                    end else if (r_next_fresh != CNT_W'(SLOTS)) begin
                        // hand out the next never-used index
                        w_slot_we    = 1'b1;
                        w_slot_waddr = r_next_fresh[IDX_W-1:0];
                        n_next_fresh = r_next_fresh + CNT_W'(1);
                    end
                    if (w_slot_we) begin
                        n_gen                 = r_gen + CODE_W'(1);
                        n_in_use[w_slot_waddr] = 1'b1;
                        n_status              = ST_OK;
                        n_res_idx             = w_slot_waddr;
                        n_res_code            = n_gen;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
                OP_FREE: begin
                    if (r_idx != '0 && r_in_use[r_idx] && r_free_count != CNT_W'(SLOTS)) begin
                        n_in_use[r_idx] = 1'b0;
                        w_stk_we        = 1'b1;
                        n_free_count    = r_free_count + CNT_W'(1);
                        n_status        = ST_OK;
                    end
                end
                OP_LOOKUP: begin
                    if (r_in_use[r_idx] && w_gen_fwd == r_code_in) begin
                        n_status    = ST_OK;
                        n_found_ref = w_ref_fwd;
                    end else begin
                        n_status = ST_NOTFOUND;
                    end
                end
                default: begin
                    n_status = ST_BAD;
                end
            endcase
        end
    end

    // hold the table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use     <= '0;
            r_free_count <= '0;
            r_next_fresh <= CNT_W'(1);
            r_gen        <= '0;
        end else begin
            r_in_use     <= n_in_use;
            r_free_count <= n_free_count;
            r_next_fresh <= n_next_fresh;
            r_gen        <= n_gen;
        end
    end

    // slot stores: write on allocate, read at the incoming index
    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            slot_ref_mem[w_slot_waddr] <= r_obj;
        end
        if (w_in_acc) begin
            r_ref_rd <= slot_ref_mem[s_axis_tdata[IN_IDX_LO +: IDX_W]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            slot_gen_mem[w_slot_waddr] <= n_gen;
        end
        if (w_in_acc) begin
            r_gen_rd <= slot_gen_mem[s_axis_tdata[IN_IDX_LO +: IDX_W]];
        end
    end

    // free stack: push on free, read the top as it will stand
    assign w_stk_raddr = IDX_W'(n_free_count - CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            stack_mem[w_stk_waddr] <= r_idx;
        end
        if (w_in_acc) begin
            r_stk_rd <= stack_mem[w_stk_raddr];
        end
    end

    // record the last write of each store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_wr_valid <= 1'b0;
            r_stk_wr_valid  <= 1'b0;
        end else begin
            if (w_slot_we) begin
                r_slot_wr_valid <= 1'b1;
            end
            if (w_stk_we) begin
                r_stk_wr_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            r_slot_wr_addr <= w_slot_waddr;
            r_slot_wr_ref  <= r_obj;
            r_slot_wr_gen  <= n_gen;
        end
        if (w_stk_we) begin
            r_stk_wr_addr <= w_stk_waddr;
            r_stk_wr_data <= r_idx;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_status    <= n_status;
            r_res_idx   <= n_res_idx;
            r_res_code  <= n_res_code;
            r_found_ref <= n_found_ref;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_W - OUT_BITS)'(0), r_found_ref, r_res_code, r_res_idx,
                            r_status};

    // checks
    a_count_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'($countones(r_in_use)) == r_next_fresh - CNT_W'(1) - r_free_count)
        else $error("in-use count disagrees with fresh index and free count");

    a_reserved_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_use[0])
        else $error("reserved index marked in use");

    a_fresh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_fresh != '0 && r_next_fresh <= CNT_W'(SLOTS))
        else $error("fresh index out of range");

    a_alloc_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit && r_op == OP_ALLOC && n_status == ST_OK
        |=> r_in_use[r_res_idx] && r_res_code == r_gen)
        else $error("allocated slot not marked or code not current generation");

    a_free_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit && r_op == OP_FREE && n_status == ST_OK
        |=> !r_in_use[$past(r_idx)] && r_free_count == $past(r_free_count) + CNT_W'(1))
        else $error("freed slot still in use or stack not pushed");

endmodule
